[rtl/isb_pkg.sv]
// Shared types and constants for the interval seat booking block.
// No dependencies; used by isb_ctrl, isb_dp and the top level.
package isb_pkg;

  // field widths of the command and result ports
  localparam int SlotW = 11;
  localparam int SeatW = 16;
  // slot position width, wide enough for any slot count up to 4096 plus one
  localparam int PosW  = 13;

  // command codes
  localparam logic CMD_BOOK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;    // write zero at the pointer, advance
    logic load;      // capture the item, pointer to range start
    logic rd;        // read slot at the pointer, advance
    logic rd_add;    // the read feeds the add pass, not the peak scan
    logic check;     // decide whether the booking fits
    logic restart;   // pointer back to range start
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // pointer on the last slot during clearing
    logic at_end;    // pointer reached the range end
    logic rd_pend;   // a read is still in flight
    logic fits;      // booking may be applied
  } sts_t;

endpackage

[rtl/isb_ctrl.sv]
// Controller of the seat booking block: clearing pass, scan, check, add.
// Depends on isb_pkg for cmd_t and sts_t.
module isb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  input  isb_pkg::sts_t sts,
  output isb_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_CHECK, S_ADD} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.at_end) cmd.rd = 1'b1;
        else if (!sts.rd_pend) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.fits) begin
          cmd.restart = 1'b1;
          state_nxt   = S_ADD;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_ADD: begin
        if (!sts.at_end) begin
          cmd.rd     = 1'b1;
          cmd.rd_add = 1'b1;
        end else if (!sts.rd_pend) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_SCAN)
    else $error("accepted item did not start a scan");
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |=> (state_r == S_CLEAR || state_r == S_IDLE))
    else $error("clearing pass left to a working state");

endmodule

[rtl/isb_dp.sv]
// Datapath of the seat booking block: slot occupancy memory, pointer,
// peak register and fit check. Depends on isb_pkg.
module isb_dp #(
  parameter int NUM_SLOTS = 1440
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  isb_pkg::cmd_t                 cmd,
  output isb_pkg::sts_t                 sts,
  input  logic                          in_command,
  input  logic [isb_pkg::SlotW-1:0]     in_start_slot,
  input  logic [isb_pkg::SlotW-1:0]     in_end_slot,
  input  logic [isb_pkg::SeatW-1:0]     in_seats,
  input  logic [isb_pkg::SeatW-1:0]     in_capacity,
  output logic                          out_accepted,
  output logic [isb_pkg::SeatW-1:0]     out_peak_used
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW = isb_pkg::PosW;
  localparam logic [PW-1:0] NSLOTS = PW'(NUM_SLOTS);
  localparam logic [PW-1:0] LAST   = PW'(NUM_SLOTS - 1);

  logic [isb_pkg::SeatW-1:0] mem [NUM_SLOTS];

  logic                      cmd_r;
  logic [PW-1:0]             start_r, end_r, ptr_r;
  logic [isb_pkg::SeatW-1:0] seats_r, cap_r, peak_r, rdata_r;
  logic [AW-1:0]             raddr_r;
  logic                      rd_vld_r, rd_add_r, acc_r;
  logic [PW-1:0]             end_ext, end_clamp;
  logic [isb_pkg::SeatW:0]   need;

  // clamp the range end to the day
  assign end_ext   = PW'(in_end_slot);
  assign end_clamp = (end_ext > NSLOTS) ? NSLOTS : end_ext;
  assign need      = {1'b0, peak_r} + {1'b0, seats_r};

  assign sts.clr_last = (ptr_r == LAST);
  assign sts.at_end   = (ptr_r >= end_r);
  assign sts.rd_pend  = rd_vld_r;
  assign sts.fits     = (cmd_r == isb_pkg::CMD_BOOK) && (start_r < end_r) &&
                        (need <= {1'b0, cap_r});

  // capture the item, advance or restart the pointer, record the fit decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      peak_r <= '0;
      acc_r  <= 1'b0;
    end else if (cmd.load) begin
      cmd_r   <= in_command;
      start_r <= PW'(in_start_slot);
      end_r   <= end_clamp;
      seats_r <= in_seats;
      cap_r   <= in_capacity;
      ptr_r   <= PW'(in_start_slot);
      peak_r  <= '0;
      acc_r   <= 1'b0;
    end else begin
      if (cmd.restart) ptr_r <= start_r;
      else if (cmd.rd || cmd.clr_wr) ptr_r <= (cmd.clr_wr && ptr_r == LAST) ? '0 : ptr_r + 1'b1;
      if (cmd.check) acc_r <= sts.fits;
      // fold scanned slots into the peak
      if (rd_vld_r && !rd_add_r && rdata_r > peak_r) peak_r <= rdata_r;
    end
  end

  // track the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_add_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      rd_add_r <= cmd.rd_add;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    raddr_r <= ptr_r[AW-1:0];
    if (cmd.rd) rdata_r <= mem[ptr_r[AW-1:0]];
  end

  // write port: clear to zero, or add seats to the slot read last cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem[ptr_r[AW-1:0]] <= '0;
    else if (rd_vld_r && rd_add_r) mem[raddr_r] <= rdata_r + seats_r;
  end

  assign out_accepted  = acc_r;
  assign out_peak_used = peak_r;

endmodule

[rtl/interval_seat_booking_range_max_unit.sv]
// Top level of the interval seat booking block: range add, range peak.
// Depends on isb_pkg, isb_ctrl and isb_dp.
//
//  channel  | handshake              | ports
//  ---------+------------------------+---------------------------------------
//  command  | start & !busy          | in_command in_start_slot in_end_slot
//           |                        | in_seats in_capacity
//  result   | out_valid, one cycle   | out_accepted out_peak_used
//
// A query or a rejected booking makes a scan pass over the clamped range for
// the peak; a fitting booking adds a read-modify-write pass for the add. Both
// passes make one slot memory access per cycle.
// After reset a clearing pass over all NUM_SLOTS slots zeroes the memory; busy
// stays high meanwhile. The receiver cannot stall; one item is in work at
// a time and busy is low again in the cycle the result strobe shows.
module interval_seat_booking_range_max_unit #(
  parameter int NUM_SLOTS = 1440
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic [isb_pkg::SlotW-1:0] in_start_slot,
  input  logic [isb_pkg::SlotW-1:0] in_end_slot,
  input  logic [isb_pkg::SeatW-1:0] in_seats,
  input  logic [isb_pkg::SeatW-1:0] in_capacity,
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic [isb_pkg::SeatW-1:0] out_peak_used
);

  isb_pkg::cmd_t cmd;
  isb_pkg::sts_t sts;

  // sequence the passes
  isb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot memory and arithmetic
  isb_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (in_command),
    .in_start_slot (in_start_slot),
    .in_end_slot   (in_end_slot),
    .in_seats      (in_seats),
    .in_capacity   (in_capacity),
    .out_accepted  (out_accepted),
    .out_peak_used (out_peak_used)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the interval seat booking block (range add, range peak).
// Depends on isb_pkg and the RTL top level; keeps its own flat per-slot occupancy model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots  = 1440;
  localparam int CycleCap  = 12000000;

  typedef struct packed {
    logic                      command;
    logic [isb_pkg::SlotW-1:0] start_slot;
    logic [isb_pkg::SlotW-1:0] end_slot;
    logic [isb_pkg::SeatW-1:0] seats;
    logic [isb_pkg::SeatW-1:0] capacity;
  } booking_req_t;

  typedef struct packed {
    logic                      accepted;
    logic [isb_pkg::SeatW-1:0] peak_used;
  } booking_resp_t;

  typedef struct {
    booking_req_t req;
    int           idle_pct;
    bit           drain;
  } queued_req_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_command = 1'b0;
  logic [isb_pkg::SlotW-1:0] in_start_slot = '0;
  logic [isb_pkg::SlotW-1:0] in_end_slot = '0;
  logic [isb_pkg::SeatW-1:0] in_seats = '0;
  logic [isb_pkg::SeatW-1:0] in_capacity = '0;
  logic                      out_valid;
  logic                      out_accepted;
  logic [isb_pkg::SeatW-1:0] out_peak_used;

  logic [isb_pkg::SeatW-1:0] slot_occ [NumSlots];
  queued_req_t               req_queue[$];
  booking_resp_t             resp_queue[$];
  int                        fail_count = 0;
  int                        cycle_count = 0;

  interval_seat_booking_range_max_unit #(.NUM_SLOTS(NumSlots)) dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_start_slot, .in_end_slot, .in_seats, .in_capacity,
    .out_valid, .out_accepted, .out_peak_used
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predict one command against the per-slot occupancy and apply a fitting booking
  function automatic booking_resp_t book_or_query(booking_req_t r);
    booking_resp_t resp;
    int            lo;
    int            hi;
    int            peak;
    lo   = int'(r.start_slot);
    hi   = (int'(r.end_slot) > NumSlots) ? NumSlots : int'(r.end_slot);
    peak = 0;
    resp = '0;
    if (lo < hi) begin
      for (int i = lo; i < hi; i++)
        if (int'(slot_occ[i]) > peak) peak = int'(slot_occ[i]);
      resp.peak_used = peak[isb_pkg::SeatW-1:0];
      if (r.command == isb_pkg::CMD_BOOK && peak + int'(r.seats) <= int'(r.capacity)) begin
        resp.accepted = 1'b1;
        for (int i = lo; i < hi; i++) slot_occ[i] = slot_occ[i] + r.seats;
      end
    end
    return resp;
  endfunction

  function automatic booking_req_t make_req(logic cmd, int s, int e, int st, int cap);
    booking_req_t r;
    r.command    = cmd;
    r.start_slot = s[isb_pkg::SlotW-1:0];
    r.end_slot   = e[isb_pkg::SlotW-1:0];
    r.seats      = st[isb_pkg::SeatW-1:0];
    r.capacity   = cap[isb_pkg::SeatW-1:0];
    return r;
  endfunction

  task automatic push_req(booking_req_t r, int idle_pct, bit drain);
    queued_req_t q;
    q.req      = r;
    q.idle_pct = idle_pct;
    q.drain    = drain;
    req_queue.push_back(q);
  endtask

  function automatic booking_req_t random_req();
    int  kind;
    int  s;
    int  e;
    int  st;
    int  cap;
    logic cmd;
    kind = $urandom_range(0, 99);
    cmd  = 1'($urandom_range(0, 1));
    if (kind < 8) begin
      // noise: every field over its full width
      return make_req(cmd, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
    if (kind < 11) begin
      s = $urandom_range(0, 200);
      e = $urandom_range(1200, 2047);
    end else begin
      s = $urandom_range(0, NumSlots - 1);
      e = s + $urandom_range(1, 32);
    end
    case ($urandom_range(0, 3))
      0: st = $urandom_range(0, 65535);
      default: st = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 3))
      0: cap = $urandom_range(0, 65535);
      1: cap = $urandom_range(0, 600);
      default: cap = 65535;
    endcase
    return make_req(cmd, s, e, st, cap);
  endfunction

  // Fill the item queue: directed corners, then three random phases
  initial begin
    foreach (slot_occ[i]) slot_occ[i] = '0;
    push_req(make_req(isb_pkg::CMD_QUERY, 0, 1440, 0, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_BOOK, 5, 5, 10, 100), 20, 0);          // empty range
    push_req(make_req(isb_pkg::CMD_BOOK, 9, 3, 10, 100), 20, 0);          // start above end
    push_req(make_req(isb_pkg::CMD_BOOK, 1440, 2047, 1, 65535), 20, 0);   // start past the day
    push_req(make_req(isb_pkg::CMD_BOOK, 2047, 2047, 65535, 65535), 20, 0);
    push_req(make_req(isb_pkg::CMD_BOOK, 0, 1, 65535, 65535), 20, 0);     // first slot full
    push_req(make_req(isb_pkg::CMD_QUERY, 0, 2, 65535, 65535), 20, 0);
    push_req(make_req(isb_pkg::CMD_BOOK, 0, 1, 0, 65535), 20, 0);         // zero seats fits
    push_req(make_req(isb_pkg::CMD_BOOK, 0, 1, 1, 65535), 20, 0);         // overflow rejected
    push_req(make_req(isb_pkg::CMD_BOOK, 1439, 2047, 300, 300), 20, 0);   // end clamped
    push_req(make_req(isb_pkg::CMD_BOOK, 1400, 1440, 1, 300), 20, 0);     // one over capacity
    push_req(make_req(isb_pkg::CMD_BOOK, 1400, 1440, 0, 299), 20, 0);     // peak over cap
    push_req(make_req(isb_pkg::CMD_BOOK, 1, 1440, 7, 7), 20, 0);          // all but slot 0
    push_req(make_req(isb_pkg::CMD_BOOK, 700, 720, 5, 20), 20, 0);
    push_req(make_req(isb_pkg::CMD_QUERY, 690, 730, 0, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_QUERY, 719, 720, 0, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_QUERY, 1439, 1440, 0, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_QUERY, 1024, 1025, 0, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_BOOK, 1000, 1100, 65535, 0), 20, 0);
    push_req(make_req(isb_pkg::CMD_QUERY, 0, 2047, 0, 0), 20, 0);
    for (int i = 0; i < 250; i++) push_req(random_req(), 20, 0);
    for (int i = 0; i < 250; i++) push_req(random_req(), 74, i == 120);
    for (int i = 0; i < 250; i++) push_req(random_req(), 0, 0);
  end

  // Hold reset from the start, release it at a falling edge
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Driver: present the front item at the falling edge, idle at random; a drain item waits for all results
  always @(negedge clk) begin
    if (rst_n && req_queue.size() > 0 &&
        !(req_queue[0].drain && resp_queue.size() > 0) &&
        ($urandom_range(0, 99) >= req_queue[0].idle_pct)) begin
      start         <= 1'b1;
      in_command    <= req_queue[0].req.command;
      in_start_slot <= req_queue[0].req.start_slot;
      in_end_slot   <= req_queue[0].req.end_slot;
      in_seats      <= req_queue[0].req.seats;
      in_capacity   <= req_queue[0].req.capacity;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check the strobed result, then predict any item taken at this edge
  always @(posedge clk) begin
    booking_resp_t want;
    if (rst_n && out_valid) begin
      if (resp_queue.size() == 0) begin
        $error("result with no item outstanding: accepted=%0d peak_used=%0d",
               out_accepted, out_peak_used);
        fail_count++;
      end else begin
        want = resp_queue.pop_front();
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_accepted);
          fail_count++;
        end
        if (out_peak_used !== want.peak_used) begin
          $error("peak_used: expected %0d, got %0d", want.peak_used, out_peak_used);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      resp_queue.push_back(book_or_query(make_req(in_command, int'(in_start_slot),
                                                  int'(in_end_slot), int'(in_seats),
                                                  int'(in_capacity))));
      void'(req_queue.pop_front());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("interval_seat_booking_range_max_unit test failed");
      $finish;
    end
  end

  // Wait for the queues to drain and a settling margin, then report
  initial begin
    @(posedge rst_n);
    do @(posedge clk); while (req_queue.size() > 0 || resp_queue.size() > 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && resp_queue.size() == 0) begin
      $display("interval_seat_booking_range_max_unit test passed");
    end else begin
      $display("interval_seat_booking_range_max_unit test failed");
    end
    $finish;
  end

endmodule
